// ===== rtl/lmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants for the LED matrix row scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

	localparam int ROW_SEL_W = 5;
	localparam int COL_W     = 10;
	localparam int HOLD_W    = 8;
	localparam int CMD_W     = 2;
	localparam int CFG_W     = 8;

	localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

	localparam logic REG_LONG_PRESS  = 1'b0;
	localparam logic REG_SHORT_PRESS = 1'b1;

	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 8'd50;
	localparam logic [CFG_W-1:0] SHORT_PRESS_RESET = 8'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_SCAN  = 2'd1,
		CMD_KEY   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic                 key_down;
		logic [COL_W-1:0]     bits;
		logic [ROW_SEL_W-1:0] row;
	} in_item_t;

	typedef struct packed {
		logic                 trace_active;
		logic                 status_led;
		logic [COL_W-1:0]     column_bits;
		logic [ROW_SEL_W-1:0] row_select;
	} out_item_t;

endpackage

// ===== rtl/led_matrix_row_scanner_top.sv =====
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_top
// Frame store and row scan control for a multiplexed LED matrix.
//
// Slave stream: one transaction per command. tuser carries the command
// (write row, scan tick, key tick), tdata the row, column bits and key level.
// Master stream: exactly one result transaction per command. tuser is the
// drive flag, tdata the row select, column word, status LED and trace flag.
// A command accepted on the slave side passes the input register, then the
// result register, before its result shows on the master side.
// Throughput: one command per cycle while the master side takes results;
// the input register lets one more command in while a result is stalled,
// after that tready drops until the receiver takes the waiting result.
// Reset clears the frame store, row counter, hold counter, trace mode and
// both stream valids; the press thresholds return to 50 and 3.
// The APB port holds the long press and short press thresholds at byte
// addresses 0 and 4; write them only while the stream is idle.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_top #(
	parameter int ROW_COUNT    = 21,
	parameter int COLUMN_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// write_row[4:0], write_bits[14:5], key_down[15]
	input  logic [15:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// row_select[4:0], column_bits[14:5], status_led[15], trace_active[16], zero fill
	output logic [23:0] m_axis_tdata,
	// drive_valid[0]
	output logic        m_axis_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int COL_W   = lmrs_pkg::COL_W;
	localparam int ROW_SEL_W = lmrs_pkg::ROW_SEL_W;
	localparam int HOLD_W  = lmrs_pkg::HOLD_W;
	localparam int CFG_W   = lmrs_pkg::CFG_W;
	localparam int FRAME_W = (COLUMN_COUNT < COL_W) ? COLUMN_COUNT : COL_W;
	localparam int ROW_W   = $clog2(ROW_COUNT);
	localparam logic [ROW_SEL_W:0]   ROW_LIMIT = (ROW_SEL_W+1)'(ROW_COUNT);
	localparam logic [ROW_SEL_W-1:0] ROW_LAST  = ROW_SEL_W'(ROW_COUNT - 1);

	logic [CFG_W-1:0]     long_press_q;
	logic [CFG_W-1:0]     short_press_q;
	logic                 cfg_wr;

	logic                 valid_s1;
	lmrs_pkg::cmd_t       cmd_s1;
	lmrs_pkg::in_item_t   item_s1;

	logic [FRAME_W-1:0]   frame_q [ROW_COUNT];
	logic [ROW_SEL_W-1:0] scan_row_q;
	logic [HOLD_W-1:0]    hold_q;
	logic                 trace_q;

	logic                 out_valid_q;
	logic                 out_drive_q;
	lmrs_pkg::out_item_t  out_q;

	logic                 advance;
	logic                 drive;
	logic                 short_release;
	logic [ROW_SEL_W-1:0] row_next;
	logic [HOLD_W-1:0]    hold_inc;
	logic [HOLD_W-1:0]    hold_next;
	logic                 trace_next;
	logic [FRAME_W-1:0]   row_word;
	lmrs_pkg::out_item_t  result;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= lmrs_pkg::LONG_PRESS_RESET;
			short_press_q <= lmrs_pkg::SHORT_PRESS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				lmrs_pkg::REG_LONG_PRESS:  long_press_q  <= pwdata[CFG_W-1:0];
				lmrs_pkg::REG_SHORT_PRESS: short_press_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lmrs_pkg::REG_LONG_PRESS:  prdata = 32'(long_press_q);
			lmrs_pkg::REG_SHORT_PRESS: prdata = 32'(short_press_q);
			default:                   prdata = '0;
		endcase
	end

	// handshake
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= lmrs_pkg::cmd_t'(s_axis_tuser);
			item_s1 <= s_axis_tdata;
		end
	end

	// command decode
	assign row_word = frame_q[scan_row_q[ROW_W-1:0]];
	assign row_next = (scan_row_q == ROW_LAST) ? '0 : scan_row_q + 1'b1;
	assign hold_inc = hold_q + 1'b1;

	assign short_release = (hold_q != '0) && (hold_q >= short_press_q) &&
		(hold_q < long_press_q) && trace_q;

	always_comb begin
		drive      = 1'b0;
		hold_next  = hold_q;
		trace_next = trace_q;
		case (cmd_s1)
			lmrs_pkg::CMD_SCAN: begin
				drive = ~trace_q;
			end
			lmrs_pkg::CMD_KEY: begin
				if (item_s1.key_down) begin
					if (hold_q != lmrs_pkg::HOLD_MAX) begin
						hold_next = hold_inc;
						if (hold_inc == long_press_q)
							trace_next = ~trace_q;
					end
				end else begin
					drive     = short_release;
					hold_next = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result.row_select   = drive ? scan_row_q : '0;
		result.column_bits  = drive ? COL_W'(row_word) : '0;
		result.status_led   = drive ? row_next[0] : scan_row_q[0];
		result.trace_active = trace_next;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			hold_q     <= '0;
			trace_q    <= 1'b0;
			for (int i = 0; i < ROW_COUNT; i++)
				frame_q[i] <= '0;
		end else if (advance) begin
			hold_q  <= hold_next;
			trace_q <= trace_next;
			if (drive)
				scan_row_q <= row_next;
			if (cmd_s1 == lmrs_pkg::CMD_WRITE && {1'b0, item_s1.row} < ROW_LIMIT)
				frame_q[item_s1.row[ROW_W-1:0]] <= FRAME_W'(item_s1.bits);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_drive_q <= drive;
			out_q       <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_drive_q;
	assign m_axis_tdata  = 24'(out_q);

endmodule

// ===== rtl/lmrs_checker.sv =====
// ----------------------------------------------------------------------------
// lmrs_checker
// Port-level checks for the LED matrix row scanner, bound to the top level.
// ----------------------------------------------------------------------------
module lmrs_checker #(
	parameter int ROW_COUNT = 21
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	localparam logic [4:0] ROW_LAST = 5'(ROW_COUNT - 1);

	logic [4:0] row_sel;
	assign row_sel = m_axis_tdata[4:0];

	// stalled result transaction holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// no row driven means row and columns are zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[14:0] == 15'd0)
		else $error("row or columns nonzero without drive");

	// driven row lies in the matrix
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> row_sel <= ROW_LAST)
		else $error("row select out of range");

	// status led follows the parity of the advanced row counter
	a_led_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[15] == ((row_sel == ROW_LAST) ? 1'b0 : ~row_sel[0]))
		else $error("status led does not match next row");

endmodule

bind led_matrix_row_scanner_top lmrs_checker #(
	.ROW_COUNT(ROW_COUNT)
) u_lmrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix row scanner. A directed table covers
// reset values, out-of-range writes, the unused command, short and long
// presses and trace stepping. Random phases follow under several threshold
// settings, mostly press and release sequences mixed with scans and writes.
// Every result is checked field by field against the table or an in-bench
// prediction of the frame store, row counter, hold counter and trace mode.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CMD_W     = lmrs_pkg::CMD_W;
	localparam int ROW_SEL_W = lmrs_pkg::ROW_SEL_W;
	localparam int COL_W     = lmrs_pkg::COL_W;
	localparam int HOLD_W    = lmrs_pkg::HOLD_W;
	localparam int CFG_W     = lmrs_pkg::CFG_W;

	localparam int ROWS = 21;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic                 drive;
		logic [ROW_SEL_W-1:0] row_sel;
		logic [COL_W-1:0]     cols;
		logic                 led;
		logic                 trace;
	} scan_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [ROW_SEL_W-1:0] row;
		logic [COL_W-1:0]     bits;
		logic                 key;
		logic                 typed;
		scan_result_t         res;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predicted block state
	logic [COL_W-1:0]     frame_copy [ROWS];
	logic [ROW_SEL_W-1:0] row_ctr;
	logic [HOLD_W-1:0]    hold_ctr;
	logic                 trace_q;
	logic                 led_q;
	logic [CFG_W-1:0]     long_q;
	logic [CFG_W-1:0]     short_q;

	scan_result_t pending_results [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sent_total = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 88;

	step_t directed_tbl [25] = '{
		'{lmrs_pkg::CMD_SCAN, 5'd0, 10'h000, 1'b0, 1'b1, '{1'b1, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_WRITE, 5'd0, 10'h3ff, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_WRITE, 5'd20, 10'h155, 1'b0, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_WRITE, 5'd31, 10'h3ff, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_WRITE, 5'd21, 10'h2aa, 1'b0, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{CMD_UNUSED, 5'd31, 10'h3ff, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_KEY, 5'd0, 10'h000, 1'b0, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_SCAN, 5'd31, 10'h3ff, 1'b1, 1'b1, '{1'b1, 5'd1, 10'h000, 1'b0, 1'b0}},
		'{lmrs_pkg::CMD_WRITE, 5'd2, 10'h200, 1'b0, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b0, 1'b0}},
		'{lmrs_pkg::CMD_SCAN, 5'd0, 10'h000, 1'b0, 1'b1, '{1'b1, 5'd2, 10'h200, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_KEY, 5'd5, 10'h00f, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_KEY, 5'd10, 10'h0f0, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_KEY, 5'd16, 10'h300, 1'b1, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_KEY, 5'd0, 10'h000, 1'b0, 1'b1, '{1'b0, 5'd0, 10'h000, 1'b1, 1'b0}},
		'{lmrs_pkg::CMD_SCAN, 5'd0, 10'h000, 1'b0, 1'b1, '{1'b1, 5'd3, 10'h000, 1'b0, 1'b0}},
		// thresholds 2 and 1 from here on
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b1, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b1, 1'b0, '0},
		'{lmrs_pkg::CMD_SCAN, 5'd0,  10'h000, 1'b0, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b0, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b1, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b0, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd31, 10'h3ff, 1'b1, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b1, 1'b0, '0},
		'{lmrs_pkg::CMD_KEY,  5'd0,  10'h000, 1'b0, 1'b0, '0},
		'{lmrs_pkg::CMD_SCAN, 5'd0,  10'h000, 1'b0, 1'b0, '0}
	};

	led_matrix_row_scanner_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("led_matrix_row_scanner_top: mismatch");
			$finish;
		end
	end

	function automatic scan_result_t drive_current_row();
		scan_result_t r;
		r = '0;
		r.drive = 1'b1;
		r.row_sel = row_ctr;
		r.cols = frame_copy[row_ctr];
		row_ctr = (row_ctr == ROWS - 1) ? '0 : row_ctr + 1'b1;
		led_q = row_ctr[0];
		return r;
	endfunction

	function automatic scan_result_t predict_scan_result(input logic [CMD_W-1:0] cmd,
			input logic [ROW_SEL_W-1:0] row, input logic [COL_W-1:0] bits, input logic key);
		scan_result_t r;
		r = '0;
		case (cmd)
			lmrs_pkg::CMD_WRITE: begin
				if (row < ROWS)
					frame_copy[row] = bits;
			end
			lmrs_pkg::CMD_SCAN: begin
				if (!trace_q)
					r = drive_current_row();
			end
			lmrs_pkg::CMD_KEY: begin
				if (key) begin
					if (hold_ctr != lmrs_pkg::HOLD_MAX) begin
						hold_ctr = hold_ctr + 1'b1;
						if (hold_ctr == long_q)
							trace_q = ~trace_q;
					end
				end else begin
					if (hold_ctr != 0 && hold_ctr >= short_q && hold_ctr < long_q && trace_q)
						r = drive_current_row();
					hold_ctr = '0;
				end
			end
			default: ;
		endcase
		r.led = led_q;
		r.trace = trace_q;
		return r;
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ROW_SEL_W-1:0] row,
			input logic [COL_W-1:0] bits, input logic key, input logic typed,
			input scan_result_t typed_res);
		scan_result_t pred;
		if (sent_total < 320) begin
			send_idle_pct = 8;
			recv_idle_pct = 88;
		end else if (sent_total < 640) begin
			send_idle_pct = 88;
			recv_idle_pct = 8;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {key, bits, row};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = predict_scan_result(cmd, row, bits, key);
		pending_results.push_back(typed ? typed_res : pred);
		sent_total++;
	endtask

	task automatic send_random(input logic [CMD_W-1:0] cmd, input logic key);
		send_item(cmd, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)), key,
			1'b0, '0);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [CFG_W-1:0] val);
		logic [31:0] fill;
		fill = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {fill[31:8], val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_thresholds(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] sp);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		apb_write(lmrs_pkg::REG_LONG_PRESS, lp);
		long_q = lp;
		apb_write(lmrs_pkg::REG_SHORT_PRESS, sp);
		short_q = sp;
		@(posedge clk);
	endtask

	task automatic press_sequence();
		int n;
		case ($urandom_range(0, 5))
			0: n = (short_q > 1) ? int'(short_q) - 1 : 0;
			1: n = int'(short_q);
			2: n = int'($urandom_range(1, (long_q > 1) ? int'(long_q) - 1 : 1));
			3: n = (long_q == 0) ? int'($urandom_range(1, 5)) : int'(long_q);
			4: n = int'(long_q) + int'($urandom_range(1, 3));
			default: n = int'($urandom_range(1, 6));
		endcase
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_random(lmrs_pkg::CMD_SCAN, 1'($urandom_range(0, 1)));
			send_random(lmrs_pkg::CMD_KEY, 1'b1);
		end
		send_random(lmrs_pkg::CMD_KEY, 1'b0);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] sp,
			input int budget);
		int stop;
		int pick;
		set_thresholds(lp, sp);
		stop = sent_total + budget;
		while (sent_total < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				press_sequence();
			else if (pick < 60)
				send_random(lmrs_pkg::CMD_SCAN, 1'($urandom_range(0, 1)));
			else if (pick < 85)
				send_item(lmrs_pkg::CMD_WRITE,
					5'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 20) :
						$urandom_range(21, 31)),
					10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b0, '0);
			else if (pick < 90)
				send_random(CMD_UNUSED, 1'($urandom_range(0, 1)));
			else
				send_random(lmrs_pkg::CMD_KEY, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic take_result();
		scan_result_t got;
		scan_result_t want;
		got.drive = m_axis_tuser;
		got.row_sel = m_axis_tdata[4:0];
		got.cols = m_axis_tdata[14:5];
		got.led = m_axis_tdata[15];
		got.trace = m_axis_tdata[16];
		if (pending_results.size() == 0) begin
			if (mismatch_count < MAX_REPORTS)
				$display("unexpected transaction: drv %0b row %0d cols %h led %0b trace %0b",
					got.drive, got.row_sel, got.cols, got.led, got.trace);
			mismatch_count++;
		end else begin
			want = pending_results.pop_front();
			if (got.drive !== want.drive || got.row_sel !== want.row_sel ||
					got.cols !== want.cols || got.led !== want.led ||
					got.trace !== want.trace) begin
				if (mismatch_count < MAX_REPORTS)
					$display("bad transaction: exp drv %0b row %0d cols %h led %0b trace %0b, got drv %0b row %0d cols %h led %0b trace %0b",
						want.drive, want.row_sel, want.cols, want.led, want.trace,
						got.drive, got.row_sel, got.cols, got.led, got.trace);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				take_result();
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		logic [CFG_W-1:0] lp;
		logic [CFG_W-1:0] sp;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= lmrs_pkg::CMD_WRITE;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < ROWS; i++)
			frame_copy[i] = '0;
		row_ctr = '0;
		hold_ctr = '0;
		trace_q = 1'b0;
		led_q = 1'b0;
		long_q = lmrs_pkg::LONG_PRESS_RESET;
		short_q = lmrs_pkg::SHORT_PRESS_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 15; i++)
			send_item(directed_tbl[i].cmd, directed_tbl[i].row, directed_tbl[i].bits,
				directed_tbl[i].key, directed_tbl[i].typed, directed_tbl[i].res);
		set_thresholds(8'd2, 8'd1);
		for (int i = 15; i < 25; i++)
			send_item(directed_tbl[i].cmd, directed_tbl[i].row, directed_tbl[i].bits,
				directed_tbl[i].key, directed_tbl[i].typed, directed_tbl[i].res);

		run_phase(8'd8, 8'd3, 160);
		run_phase(8'd1, 8'd1, 100);
		run_phase(8'd254, 8'd254, 300);
		// zero threshold never toggles
		run_phase(8'd0, 8'd1, 100);
		run_phase(8'd2, 8'd1, 120);
		lp = 8'($urandom_range(3, 40));
		sp = 8'($urandom_range(1, lp));
		run_phase(lp, sp, 150);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("led_matrix_row_scanner_top: match");
		else
			$display("led_matrix_row_scanner_top: mismatch");
		$finish;
	end

endmodule

// ===== led_matrix_row_scanner_top.f =====
rtl/lmrs_pkg.sv
rtl/led_matrix_row_scanner_top.sv
rtl/lmrs_checker.sv
sim/tb_top.sv
